FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block, pket_checker.
// Each macro takes a label, a clock, a reset, and the two sides of the implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/pket_pkg.sv
`timescale 1ns / 1ps
// Package for the pair-keyed edge fix table: sizes, function codes and beat types.
// Used by every module of the block but pket_ram; it depends on nothing else.
package pket_pkg;

   // Table sizing.
   localparam int MAX_ENTRIES = 256;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   // One table word: near cell, far cell, then the arrival edges of the near and far ends.
   localparam int CELL_W  = 32;
   localparam int EDGES_W = 4;
   localparam int WORD_W  = 2 * CELL_W + EDGES_W;

   // Function codes of a request beat.
   localparam logic [1:0] FN_LOOKUP   = 2'd0;
   localparam logic [1:0] FN_REGISTER = 2'd1;
   localparam logic [1:0] FN_CLEAR    = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] near_x;
      logic [15:0] near_z;
      logic [15:0] far_x;
      logic [15:0] far_z;
      logic [1:0]  near_edge;
      logic [1:0]  far_edge;
      logic [7:0]  edge_in;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] arrival_edge;
      logic [7:0] patched_edge;
      logic       dropped;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic scan;
      logic take_match;
      logic wr_update;
      logic wr_append;
      logic set_drop;
      logic finish;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] func;
      logic       match;
      logic       scan_done;
      logic       full;
      logic       out_free;
   } status_type;

endpackage

FILE: rtl/core/pket_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; no package is needed.
module pket_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/pket_datapath.sv
`timescale 1ns / 1ps
// Datapath of the pair-keyed edge fix table: item register, table RAM, scan
// counter, pair compare and the result register. Depends on pket_pkg and pket_ram.
module pket_datapath
   import pket_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   req_type          item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             hit_ff, hit_in;
   logic [1:0]       edge_ff, edge_in;
   logic             drop_ff, drop_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic              issue_more;
   logic [CELL_W-1:0] req_near, req_far;
   logic [CELL_W-1:0] st_near, st_far;
   logic [EDGES_W-1:0] st_edges;
   logic [WORD_W-1:0] rd_word, wr_word;
   logic [IDX_W-1:0]  wr_addr;
   logic              fwd, rev;
   logic [1:0]        lk_edge;
   logic [EDGES_W-1:0] upd_edges;

   // Cells of the held item and of the entry just read.
   assign req_near = {item_ff.near_x, item_ff.near_z};
   assign req_far  = {item_ff.far_x, item_ff.far_z};
   assign st_near  = rd_word[WORD_W-1 -: CELL_W];
   assign st_far   = rd_word[EDGES_W +: CELL_W];
   assign st_edges = rd_word[EDGES_W-1:0];

   // Pair compare in both directions; forward wins when both hold.
   assign fwd       = (st_near == req_near) && (st_far == req_far);
   assign rev       = (st_far == req_near) && (st_near == req_far);
   assign lk_edge   = fwd ? st_edges[1:0] : st_edges[3:2];
   assign upd_edges = fwd ? {item_ff.near_edge, item_ff.far_edge}
                          : {item_ff.far_edge, item_ff.near_edge};

   // Table write: an edge update in place, or an append at the fill count.
   assign wr_addr = cmd.wr_update ? cmp_idx_ff : count_ff[IDX_W-1:0];
   assign wr_word = cmd.wr_update ? {st_near, st_far, upd_edges}
                                  : {req_near, req_far, item_ff.near_edge, item_ff.far_edge};

   pket_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.wr_update | cmd.wr_append),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   // Scan: one read issued per cycle, compared in the cycle after.
   assign issue_more = cmd.scan && (issue_ff < count_ff);

   always_comb begin
      item_in    = cmd.start ? req_data : item_ff;
      issue_in   = issue_ff;
      if (cmd.start) begin
         issue_in = '0;
      end else if (issue_more) begin
         issue_in = issue_ff + CNT_W'(1);
      end
      cmp_vld_in = issue_more;
      cmp_idx_in = issue_ff[IDX_W-1:0];
   end

   // Fill count.
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.wr_append) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Per-item outcome flags.
   always_comb begin
      hit_in  = hit_ff;
      edge_in = edge_ff;
      drop_in = drop_ff;
      if (cmd.start) begin
         hit_in  = 1'b0;
         edge_in = 2'b00;
         drop_in = 1'b0;
      end else begin
         if (cmd.take_match) begin
            hit_in  = 1'b1;
            edge_in = (item_ff.func == FN_LOOKUP) ? lk_edge : 2'b00;
         end
         if (cmd.set_drop) begin
            drop_in = 1'b1;
         end
      end
   end

   // Result register; a new result loads only when the old one is gone.
   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.hit          = hit_ff;
      rsp_in.arrival_edge = edge_ff;
      rsp_in.dropped      = drop_ff;
      if (hit_ff && (item_ff.func == FN_LOOKUP)) begin
         rsp_in.patched_edge = {item_ff.edge_in[7:2], edge_ff};
      end else begin
         rsp_in.patched_edge = item_ff.edge_in;
      end
      if (!cmd.finish) begin
         rsp_in = rsp_ff;
      end
      rsp_valid_in = cmd.finish | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff    <= item_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      edge_ff    <= edge_in;
      drop_ff    <= drop_in;
      rsp_ff     <= rsp_in;
   end

   // Status toward the controller.
   assign status.func      = item_ff.func;
   assign status.match     = cmp_vld_ff && (fwd || rev);
   assign status.scan_done = !cmp_vld_ff && !(issue_ff < count_ff);
   assign status.full      = (count_ff >= CNT_W'(MAX_ENTRIES));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/pket_controller.sv
`timescale 1ns / 1ps
// Controller of the pair-keyed edge fix table: sequences accept, scan and finish.
// Depends on pket_pkg; drives the datapath by command beats.
module pket_controller
   import pket_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      searching;

   assign req_stall = (state_ff != ST_IDLE);
   assign searching = (status.func == FN_LOOKUP) || (status.func == FN_REGISTER);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (searching) begin
               cmd.scan = 1'b1;
               if (status.match) begin
                  cmd.take_match = 1'b1;
                  cmd.wr_update  = (status.func == FN_REGISTER);
                  state_in       = ST_FINISH;
               end else if (status.scan_done) begin
                  if (status.func == FN_REGISTER) begin
                     cmd.set_drop  = status.full;
                     cmd.wr_append = !status.full;
                  end
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               cmd.clear  = (status.func == FN_CLEAR);
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/pair_keyed_edge_fix_table_core.sv
`timescale 1ns / 1ps
// Pair-keyed edge fix table. Holds up to MAX_ENTRIES unordered cell pairs with an
// arrival edge per end, in one RAM with a single read port. A lookup or register
// beat scans the filled entries one per cycle and stops early on the first match;
// a clear or an unused function code skips the scan. One beat is in work at a time;
// a finished result sits in an output register, so the next request beat is
// accepted while the result waits. Needs pket_pkg.
module pair_keyed_edge_fix_table_core
   import pket_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   pket_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pket_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/core/pket_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the pair-keyed edge fix table, bound to the top level.
// Depends on pket_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pket_checker
   import pket_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled request beat stays offered with the same payload.
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_data))

   // A result beat stays offered while it is stalled.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // Only one beat is in work: right after an accept, requests are held off.
   `ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && !req_stall, req_stall)

   // A dropped pair never counts as a hit and carries no edge.
   `ASSERT_IMPLY(a_drop_no_hit, clock, reset, rsp_valid && rsp_data.dropped,
                 !rsp_data.hit && (rsp_data.arrival_edge == 2'b00))

   // Without a hit the returned edge is zero.
   `ASSERT_IMPLY(a_miss_no_edge, clock, reset, rsp_valid && !rsp_data.hit,
                 rsp_data.arrival_edge == 2'b00)

endmodule

bind pair_keyed_edge_fix_table_core pket_checker u_pket_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: tb/sv/pair_keyed_edge_fix_table_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for pair_keyed_edge_fix_table_core: a scripted opening, then
// random beats over small cell pools and one full-table phase, checked by a local model.
// Depends on pket_pkg and the core RTL only.
module pair_keyed_edge_fix_table_core_test;
   import pket_pkg::*;

   // The function code that the block ignores.
   localparam logic [1:0] FN_UNUSED = 2'd3;

   // Fixed cells for the scripted opening, including the coordinate extremes.
   localparam logic [31:0] CELL_A = 32'h0000_0000;
   localparam logic [31:0] CELL_B = 32'hFFFF_FFFF;
   localparam logic [31:0] CELL_C = 32'h1234_5678;
   localparam logic [31:0] CELL_D = 32'hFFFF_0000;
   localparam logic [31:0] CELL_E = 32'h0000_FFFF;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Local copy of the pair table.
   logic [31:0] tab_near [MAX_ENTRIES];
   logic [31:0] tab_far [MAX_ENTRIES];
   logic [3:0]  tab_edges [MAX_ENTRIES];
   int          tab_fill = 0;

   rsp_type        expected_fixes [$];
   rsp_type        fix_want;
   script_row_type script [$];
   logic [31:0]    fill_near [MAX_ENTRIES];
   logic [31:0]    fill_far [MAX_ENTRIES];

   int beats_sent = 0;
   int errors = 0;
   int n_hits = 0;
   int n_misses = 0;
   int n_updates = 0;
   int n_appends = 0;
   int n_drops = 0;
   bit steady = 1'b0;

   pair_keyed_edge_fix_table_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one beat to the local table and returns the result the block owes for it.
   function automatic rsp_type predict_fix(input req_type b);
      rsp_type     r;
      logic [31:0] nc;
      logic [31:0] fc;
      bit          found;
      int          i;
      nc = {b.near_x, b.near_z};
      fc = {b.far_x, b.far_z};
      r.hit = 1'b0;
      r.arrival_edge = 2'd0;
      r.patched_edge = b.edge_in;
      r.dropped = 1'b0;
      found = 1'b0;
      case (b.func)
         FN_LOOKUP: begin
            // Directed match; the forward order wins over the reversed one.
            for (i = 0; i < tab_fill && !found; i++) begin
               if (tab_near[i] == nc && tab_far[i] == fc) begin
                  found = 1'b1;
                  r.arrival_edge = tab_edges[i][1:0];
               end else if (tab_far[i] == nc && tab_near[i] == fc) begin
                  found = 1'b1;
                  r.arrival_edge = tab_edges[i][3:2];
               end
            end
            if (found) begin
               r.hit = 1'b1;
               r.patched_edge = {b.edge_in[7:2], r.arrival_edge};
               n_hits++;
            end else begin
               n_misses++;
            end
         end
         FN_REGISTER: begin
            // Unordered match; edges are stored in the entry's own order.
            for (i = 0; i < tab_fill && !found; i++) begin
               if ((tab_near[i] == nc && tab_far[i] == fc) ||
                   (tab_near[i] == fc && tab_far[i] == nc)) begin
                  found = 1'b1;
                  tab_edges[i] = (tab_near[i] == nc) ? {b.near_edge, b.far_edge}
                                                     : {b.far_edge, b.near_edge};
               end
            end
            r.hit = found;
            if (found) begin
               n_updates++;
            end else if (tab_fill >= MAX_ENTRIES) begin
               r.dropped = 1'b1;
               n_drops++;
            end else begin
               tab_near[tab_fill] = nc;
               tab_far[tab_fill] = fc;
               tab_edges[tab_fill] = {b.near_edge, b.far_edge};
               tab_fill++;
               n_appends++;
            end
         end
         FN_CLEAR: begin
            tab_fill = 0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic req_type mk_beat(input logic [1:0] fn, input logic [31:0] nc,
                                       input logic [31:0] fc, input logic [1:0] ne,
                                       input logic [1:0] fe, input logic [7:0] ein);
      req_type b;
      b.func = fn;
      {b.near_x, b.near_z} = nc;
      {b.far_x, b.far_z} = fc;
      b.near_edge = ne;
      b.far_edge = fe;
      b.edge_in = ein;
      return b;
   endfunction

   // One scripted row; the last four arguments matter only when typed is set.
   function automatic script_row_type script_row(input logic [1:0] fn, input logic [31:0] nc,
                                                 input logic [31:0] fc, input logic [1:0] ne,
                                                 input logic [1:0] fe, input logic [7:0] ein,
                                                 input bit typed, input logic hit,
                                                 input logic [1:0] ae, input logic [7:0] pe,
                                                 input logic dr);
      script_row_type s;
      s.beat = mk_beat(fn, nc, fc, ne, fe, ein);
      s.typed = typed;
      s.want.hit = hit;
      s.want.arrival_edge = ae;
      s.want.patched_edge = pe;
      s.want.dropped = dr;
      return s;
   endfunction

   function automatic bit field_ok(input string name, input int want, input int got);
      if (want == got) return 1'b1;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1'b0;
   endfunction

   // Drives one request beat, waits for its acceptance and queues its expected result.
   task automatic send_beat(input req_type b, input bit typed, input rsp_type want);
      rsp_type predicted;
      while (!steady && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_stall);
      predicted = predict_fix(b);
      expected_fixes.push_back(typed ? want : predicted);
      if (b.func != FN_UNUSED) beats_sent++;
      steady = (beats_sent >= 350 && beats_sent < 470);
   endtask

   // Phases over a small pool of related cells, so that pairs repeat and hit often.
   task automatic run_pooled_phases(input int target);
      logic [31:0] pool [6];
      logic [31:0] nc;
      logic [31:0] fc;
      logic [1:0]  fn;
      int          len;
      int          sel;
      while (beats_sent < target) begin
         pool[0] = $urandom;
         for (int k = 1; k < 6; k++) begin
            case ($urandom_range(3))
               0: pool[k] = $urandom;
               1: pool[k] = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
               default: pool[k] = pool[0] ^ (32'd1 << $urandom_range(31));
            endcase
         end
         len = $urandom_range(70, 30);
         for (int j = 0; j < len; j++) begin
            sel = $urandom_range(99);
            nc = pool[$urandom_range(5)];
            fc = pool[$urandom_range(5)];
            if (sel < 45) begin
               fn = FN_LOOKUP;
            end else if (sel < 87) begin
               fn = FN_REGISTER;
            end else if (sel < 90) begin
               fn = FN_CLEAR;
            end else if (sel < 93) begin
               fn = FN_UNUSED;
            end else begin
               // Stray lookup with unrelated coordinates.
               fn = FN_LOOKUP;
               nc = $urandom;
               fc = $urandom;
            end
            send_beat(mk_beat(fn, nc, fc, 2'($urandom), 2'($urandom), 8'($urandom)),
                      1'b0, '0);
         end
      end
   endtask

   // Result side: random stall, and each accepted beat checked against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_fixes.size() == 0) begin
               $display("%0t ns: unexpected result beat, expected none, got %p",
                        $time, rsp_data);
               errors++;
            end else begin
               fix_want = expected_fixes.pop_front();
               if (!(field_ok("hit", fix_want.hit, rsp_data.hit) &
                     field_ok("arrival_edge", fix_want.arrival_edge, rsp_data.arrival_edge) &
                     field_ok("patched_edge", fix_want.patched_edge, rsp_data.patched_edge) &
                     field_ok("dropped", fix_want.dropped, rsp_data.dropped)))
                  errors++;
            end
         end
         rsp_stall <= !steady && ($urandom_range(99) < 8);
      end
   end

   // Stimulus and end of run.
   initial begin
      int          idx;
      logic [31:0] nc;
      logic [31:0] fc;

      // Scripted opening: empty table, ignored code, both orders, same cell at both ends.
      script.push_back(script_row(FN_LOOKUP, CELL_A, CELL_B, 2'd0, 2'd0, 8'hA5,
                                  1, 1'b0, 2'd0, 8'hA5, 1'b0));
      script.push_back(script_row(FN_UNUSED, CELL_A, CELL_B, 2'd3, 2'd3, 8'hFF,
                                  1, 1'b0, 2'd0, 8'hFF, 1'b0));
      script.push_back(script_row(FN_CLEAR, CELL_B, CELL_A, 2'd3, 2'd3, 8'h00,
                                  1, 1'b0, 2'd0, 8'h00, 1'b0));
      script.push_back(script_row(FN_REGISTER, CELL_A, CELL_B, 2'd1, 2'd2, 8'h3C,
                                  1, 1'b0, 2'd0, 8'h3C, 1'b0));
      script.push_back(script_row(FN_LOOKUP, CELL_A, CELL_B, 2'd0, 2'd0, 8'hFF,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_LOOKUP, CELL_B, CELL_A, 2'd0, 2'd0, 8'h00,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_REGISTER, CELL_B, CELL_A, 2'd3, 2'd0, 8'h81,
                                  1, 1'b1, 2'd0, 8'h81, 1'b0));
      script.push_back(script_row(FN_LOOKUP, CELL_A, CELL_B, 2'd0, 2'd0, 8'h80,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_LOOKUP, CELL_B, CELL_A, 2'd0, 2'd0, 8'h7F,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_REGISTER, CELL_C, CELL_C, 2'd2, 2'd1, 8'h55,
                                  1, 1'b0, 2'd0, 8'h55, 1'b0));
      script.push_back(script_row(FN_LOOKUP, CELL_C, CELL_C, 2'd0, 2'd0, 8'hAA,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_REGISTER, CELL_D, CELL_E, 2'd0, 2'd3, 8'hC3,
                                  1, 1'b0, 2'd0, 8'hC3, 1'b0));
      script.push_back(script_row(FN_LOOKUP, CELL_E, CELL_D, 2'd0, 2'd0, 8'h00,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_LOOKUP, CELL_D, CELL_D, 2'd0, 2'd0, 8'h5A,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_LOOKUP, CELL_A, CELL_C, 2'd0, 2'd0, 8'h0F,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_REGISTER, CELL_A, CELL_B, 2'd2, 2'd2, 8'hF0,
                                  1, 1'b1, 2'd0, 8'hF0, 1'b0));
      script.push_back(script_row(FN_LOOKUP, CELL_B, CELL_A, 2'd0, 2'd0, 8'h01,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_UNUSED, CELL_C, CELL_C, 2'd0, 2'd0, 8'h99,
                                  1, 1'b0, 2'd0, 8'h99, 1'b0));
      script.push_back(script_row(FN_LOOKUP, CELL_C, CELL_C, 2'd0, 2'd0, 8'h66,
                                  0, 0, 0, 0, 0));
      script.push_back(script_row(FN_CLEAR, CELL_A, CELL_A, 2'd0, 2'd0, 8'h42,
                                  1, 1'b0, 2'd0, 8'h42, 1'b0));
      script.push_back(script_row(FN_LOOKUP, CELL_A, CELL_B, 2'd0, 2'd0, 8'hFF,
                                  1, 1'b0, 2'd0, 8'hFF, 1'b0));
      script.push_back(script_row(FN_REGISTER, CELL_E, CELL_D, 2'd1, 2'd1, 8'h18,
                                  1, 1'b0, 2'd0, 8'h18, 1'b0));
      script.push_back(script_row(FN_LOOKUP, CELL_D, CELL_E, 2'd0, 2'd0, 8'hE7,
                                  0, 0, 0, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_beat(script[i].beat, script[i].typed, script[i].want);

      run_pooled_phases(230);

      // Hold off the sender until every outstanding result has drained.
      req_valid <= 1'b0;
      while (expected_fixes.size() != 0) @(posedge clock);

      // Fill the table to the limit with distinct pairs; near x stays below 0x100 and
      // far x at or above it, so no two pairs can match in either order.
      send_beat(mk_beat(FN_CLEAR, $urandom, $urandom, 2'd0, 2'd0, 8'($urandom)), 1'b0, '0);
      for (int k = 0; k < MAX_ENTRIES; k++) begin
         fill_near[k] = {16'(k), 16'($urandom)};
         fill_far[k] = {16'($urandom_range(16'hFFFF, 16'h0100)), 16'($urandom)};
         send_beat(mk_beat(FN_REGISTER, fill_near[k], fill_far[k], 2'($urandom),
                           2'($urandom), 8'($urandom)), 1'b0, '0);
      end

      // Full table: drops, updates, hits and whole-table misses.
      for (int j = 0; j < 30; j++) begin
         idx = ($urandom_range(3) == 0) ? MAX_ENTRIES - 1 : $urandom_range(MAX_ENTRIES - 1);
         if ($urandom_range(1)) begin
            nc = fill_near[idx];
            fc = fill_far[idx];
         end else begin
            nc = fill_far[idx];
            fc = fill_near[idx];
         end
         case ($urandom_range(3))
            0: send_beat(mk_beat(FN_REGISTER, {16'($urandom_range(16'hFFFF, 16'h0100)),
                                 16'($urandom)}, {16'($urandom_range(16'hFFFF, 16'h0100)),
                                 16'($urandom)}, 2'($urandom), 2'($urandom), 8'($urandom)),
                         1'b0, '0);
            1: send_beat(mk_beat(FN_REGISTER, nc, fc, 2'($urandom), 2'($urandom),
                                 8'($urandom)), 1'b0, '0);
            2: send_beat(mk_beat(FN_LOOKUP, nc, fc, 2'($urandom), 2'($urandom),
                                 8'($urandom)), 1'b0, '0);
            default: send_beat(mk_beat(FN_LOOKUP, nc, nc, 2'($urandom), 2'($urandom),
                                       8'($urandom)), 1'b0, '0);
         endcase
      end

      run_pooled_phases(660);

      req_valid <= 1'b0;
      while (expected_fixes.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Ran %0d request beats over scripted, pooled and full-table phases.",
               beats_sent);
      $display("Lookups: %0d hits, %0d misses; registers: %0d updates, %0d appends, %0d drops.",
               n_hits, n_misses, n_updates, n_appends, n_drops);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #1_500_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/pket_pkg.sv
rtl/core/pket_ram.sv
rtl/core/pket_datapath.sv
rtl/core/pket_controller.sv
rtl/core/pair_keyed_edge_fix_table_core.sv
rtl/core/pket_checker.sv
tb/sv/pair_keyed_edge_fix_table_core_test.sv
